[src/lcdtn_pkg.sv]
`timescale 1ns / 1ps

package lcdtn_pkg;

    localparam int BUFFER_BYTES = 128;

    localparam logic [5:0] COLUMNS_RESET = 6'd16;
    localparam logic [2:0] ROWS_RESET    = 3'd2;
    localparam logic [2:0] ROWS_MAX      = 3'd4;

    localparam logic       REG_COLUMNS = 1'b0;
    localparam logic       REG_ROWS    = 1'b1;

    localparam logic       OP_START = 1'b0;
    localparam logic       OP_CHAR  = 1'b1;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;

    localparam logic [7:0] CMD_SET_ADDR = 8'h80;

    localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    typedef struct packed {
        logic       is_data;
        logic [7:0] value;
    } t_frame;

    typedef struct packed {
        logic   two;
        t_frame f0;
        t_frame f1;
    } t_frames;

    function automatic logic [7:0] addr_cmd(input logic [5:0] col, input logic [1:0] row);
        logic [7:0] sum;
        sum = {2'b00, col} + ROW_BASE[row];
        return CMD_SET_ADDR | sum;
    endfunction

endpackage

[src/lcd_text_to_nibble_frames_core.sv]
`timescale 1ns / 1ps
// channel | handshake                  | payload
// in      | i_in_valid / o_in_stall    | i_operation, i_character, i_start_col, i_start_row
// out     | o_out_valid / i_out_stall  | o_expander_byte, o_last_of_run
// config  | psel penable pwrite pready | paddr, pwdata, prdata
//
// An item waits in the input register, where the cursor logic turns it into zero, one or
// two frames; the serializer then sends four bytes per frame, one per cycle while
// i_out_stall is low, and a new word is taken while the last one drains.
// Reset is synchronous: cursor, row and buffer count go to zero, columns 16, rows 2.
// Stalls on the output hold the byte; the input stalls only when both stages are full.

module lcd_text_to_nibble_frames_core #(
    parameter int BUFFER_BYTES = lcdtn_pkg::BUFFER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_character,
    input  logic [7:0]  i_start_col,
    input  logic [7:0]  i_start_row,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_expander_byte,
    output logic        o_last_of_run
);

    logic [5:0]         columns;
    logic [2:0]         rows_in_use;
    logic               fr_valid;
    logic               fr_ready;
    lcdtn_pkg::t_frames frames;

    lcdtn_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_columns     (columns),
        .o_rows_in_use (rows_in_use)
    );

    lcdtn_cursor #(
        .BUFFER_BYTES  (BUFFER_BYTES)
    ) u_cursor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_character   (i_character),
        .i_start_col   (i_start_col),
        .i_start_row   (i_start_row),
        .i_columns     (columns),
        .i_rows_in_use (rows_in_use),
        .o_fr_valid    (fr_valid),
        .o_frames      (frames),
        .i_fr_ready    (fr_ready)
    );

    lcdtn_serial u_serial (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fr_valid      (fr_valid),
        .i_frames        (frames),
        .o_fr_ready      (fr_ready),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_expander_byte (o_expander_byte),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

[src/lcdtn_regs.sv]
`timescale 1ns / 1ps

module lcdtn_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [5:0]  o_columns,
    output logic [2:0]  o_rows_in_use
);

    logic [5:0] r_columns;
    logic [2:0] r_rows;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= lcdtn_pkg::COLUMNS_RESET;
            r_rows    <= lcdtn_pkg::ROWS_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                lcdtn_pkg::REG_COLUMNS: r_columns <= pwdata[5:0];
                lcdtn_pkg::REG_ROWS:    r_rows    <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            lcdtn_pkg::REG_COLUMNS: prdata = {26'd0, r_columns};
            lcdtn_pkg::REG_ROWS:    prdata = {29'd0, r_rows};
            default:                prdata = 32'd0;
        endcase
    end

    assign o_columns     = r_columns;
    assign o_rows_in_use = r_rows;

endmodule

[src/lcdtn_cursor.sv]
`timescale 1ns / 1ps

module lcdtn_cursor #(
    parameter int BUFFER_BYTES = lcdtn_pkg::BUFFER_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [7:0]          i_character,
    input  logic [7:0]          i_start_col,
    input  logic [7:0]          i_start_row,
    input  logic [5:0]          i_columns,
    input  logic [2:0]          i_rows_in_use,
    output logic                o_fr_valid,
    output lcdtn_pkg::t_frames  o_frames,
    input  logic                i_fr_ready
);

    logic       r_in_valid;
    logic       r_op;
    logic [7:0] r_ch;
    logic [7:0] r_sc;
    logic [7:0] r_sr;
    logic [5:0] r_col;
    logic [1:0] r_row;
    logic [7:0] r_bytes;

    logic [5:0] n_col;
    logic [1:0] n_row;
    logic [7:0] n_bytes;

    logic [2:0] rows;
    logic       wrap;
    logic [2:0] row_inc;
    logic [1:0] wrap_row;
    logic [5:0] col1;
    logic [1:0] row1;
    logic [2:0] inc1;
    logic       ok_a;
    logic       ok_b;
    logic [7:0] bu_base;
    lcdtn_pkg::t_frame frame_a;
    lcdtn_pkg::t_frame frame_b;
    logic       any;
    logic       move;
    logic       accept;

    localparam logic [8:0] BUF_LIMIT = 9'(BUFFER_BYTES);

    always_comb begin
        rows     = (i_rows_in_use > lcdtn_pkg::ROWS_MAX) ? lcdtn_pkg::ROWS_MAX : i_rows_in_use;
        wrap     = (r_op == lcdtn_pkg::OP_CHAR) && (r_col >= i_columns);
        row_inc  = {1'b0, r_row} + 3'd1;
        wrap_row = (row_inc >= rows) ? 2'd0 : row_inc[1:0];
        col1     = wrap ? 6'd0 : r_col;
        row1     = wrap ? wrap_row : r_row;
        inc1     = {1'b0, row1} + 3'd1;

        frame_a.is_data = 1'b0;
        frame_a.value   = lcdtn_pkg::addr_cmd(6'd0, wrap_row);
        ok_a            = wrap && (({1'b0, r_bytes} + 9'd4) < BUF_LIMIT);

        n_col   = col1;
        n_row   = row1;
        frame_b = '0;
        if (r_op == lcdtn_pkg::OP_START) begin
            bu_base = 8'd0;
            n_row   = (r_sr >= {5'd0, rows}) ? 2'd0 : r_sr[1:0];
            n_col   = (r_sc >= {2'd0, i_columns}) ? 6'd0 : r_sc[5:0];
            frame_b.value = lcdtn_pkg::addr_cmd(n_col, n_row);
        end else begin
            bu_base = ok_a ? r_bytes + 8'd4 : r_bytes;
            priority if (r_ch == lcdtn_pkg::CH_NEWLINE) begin
                n_row = (inc1 >= rows) ? 2'd0 : inc1[1:0];
                n_col = (col1 >= i_columns) ? 6'd0 : col1;
                frame_b.value = lcdtn_pkg::addr_cmd(n_col, n_row);
            end else if (r_ch == lcdtn_pkg::CH_RETURN) begin
                n_row = ({1'b0, row1} >= rows) ? 2'd0 : row1;
                n_col = 6'd0;
                frame_b.value = lcdtn_pkg::addr_cmd(n_col, n_row);
            end else begin
                frame_b.is_data = 1'b1;
                frame_b.value   = r_ch;
                n_col = col1 + 6'd1;
            end
        end

        ok_b    = ({1'b0, bu_base} + 9'd4) < BUF_LIMIT;
        n_bytes = ok_b ? bu_base + 8'd4 : bu_base;
        any     = ok_a || ok_b;

        o_frames.two = ok_a && ok_b;
        o_frames.f0  = ok_a ? frame_a : frame_b;
        o_frames.f1  = frame_b;
    end

    assign move       = r_in_valid && (!any || i_fr_ready);
    assign o_fr_valid = r_in_valid && any;
    assign o_in_stall = r_in_valid && !move;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_col      <= 6'd0;
            r_row      <= 2'd0;
            r_bytes    <= 8'd0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_bytes <= n_bytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_operation;
            r_ch <= i_character;
            r_sc <= i_start_col;
            r_sr <= i_start_row;
        end
    end

endmodule

[src/lcdtn_serial.sv]
`timescale 1ns / 1ps

module lcdtn_serial (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fr_valid,
    input  lcdtn_pkg::t_frames  i_frames,
    output logic                o_fr_ready,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_expander_byte,
    output logic                o_last_of_run
);

    logic               r_valid;
    lcdtn_pkg::t_frames r_frames;
    logic [2:0]         r_idx;

    lcdtn_pkg::t_frame  cur;
    logic [3:0]         nib;
    logic               last;
    logic               take;

    // idx[2] frame, idx[1] low nibble, idx[0] enable low
    assign cur  = r_idx[2] ? r_frames.f1 : r_frames.f0;
    assign nib  = r_idx[1] ? cur.value[3:0] : cur.value[7:4];
    assign last = (r_idx == {r_frames.two, 2'b11});
    assign take = r_valid && !i_out_stall;

    assign o_fr_ready      = !r_valid || (take && last);
    assign o_out_valid     = r_valid;
    // nibble, backlight, enable, rw, rs
    assign o_expander_byte = {nib, 1'b1, ~r_idx[0], 1'b0, cur.is_data};
    assign o_last_of_run   = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (i_fr_valid && o_fr_ready) begin
            r_valid <= 1'b1;
            r_idx   <= 3'd0;
        end else if (take) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fr_valid && o_fr_ready) begin
            r_frames <= i_frames;
        end
    end

endmodule

[src/lcdtn_checker.sv]
`timescale 1ns / 1ps

module lcdtn_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_expander_byte,
    input logic       o_last_of_run
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_expander_byte)
            && $stable(o_last_of_run))
        else $error("output word changed under stall");

    a_fixed_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_expander_byte[3] && !o_expander_byte[1])
        else $error("backlight or rw bit wrong");

    a_strobe_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_expander_byte[2] |=> o_out_valid
            && !o_expander_byte[2]
            && o_expander_byte[7:3] == $past(o_expander_byte[7:3])
            && o_expander_byte[0] == $past(o_expander_byte[0]))
        else $error("enable high not followed by matching enable low");

    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_run |-> !o_expander_byte[2])
        else $error("run ends with enable high");

endmodule

bind lcd_text_to_nibble_frames_core lcdtn_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_expander_byte (o_expander_byte),
    .o_last_of_run   (o_last_of_run)
);

[verif/tb_lcd_text_to_nibble_frames_core.sv]
`timescale 1ns / 1ps

module tb_lcd_text_to_nibble_frames_core;

    localparam logic [7:0] BIT_RS = 8'h01;
    localparam logic [7:0] BIT_EN = 8'h04;
    localparam logic [7:0] BIT_BL = 8'h08;
    localparam logic [7:0] NIB_HI = 8'hF0;
    localparam int         LONG_HOLD = 300;
    localparam int         SETTLE_CYCLES = 16;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic [7:0] sc;
        logic [7:0] sr;
    } t_item;

    typedef struct packed {
        t_item       it;
        logic        typed;
        logic [3:0]  n;
        logic [63:0] bytes;
    } t_row;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_due;

    // typed rows: bytes listed low byte first
    localparam t_row DIRECTED [21] = '{
        '{'{lcdtn_pkg::OP_CHAR,  8'h48, 8'h00, 8'h00}, 1'b1, 4'd4, 64'h0000_0000_898D_494D},
        '{'{lcdtn_pkg::OP_START, 8'hFF, 8'h00, 8'h00}, 1'b1, 4'd4, 64'h0000_0000_080C_888C},
        '{'{lcdtn_pkg::OP_START, 8'h00, 8'hFF, 8'hFF}, 1'b1, 4'd4, 64'h0000_0000_080C_888C},
        '{'{lcdtn_pkg::OP_CHAR,  8'h00, 8'hFF, 8'hFF}, 1'b1, 4'd4, 64'h0000_0000_090D_090D},
        '{'{lcdtn_pkg::OP_CHAR,  8'hFF, 8'h00, 8'h00}, 1'b1, 4'd4, 64'h0000_0000_F9FD_F9FD},
        '{'{lcdtn_pkg::OP_CHAR,  8'h41, 8'h00, 8'h00}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_CHAR,  lcdtn_pkg::CH_NEWLINE, 8'h00, 8'h00}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_CHAR,  lcdtn_pkg::CH_NEWLINE, 8'h00, 8'h00}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_CHAR,  lcdtn_pkg::CH_RETURN, 8'h00, 8'h00}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_START, 8'h00, 8'd15, 8'd1}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_CHAR,  8'h7A, 8'h00, 8'h00}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_CHAR,  8'h30, 8'h00, 8'h00}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_START, 8'h00, 8'd16, 8'd2}, 1'b1, 4'd4, 64'h0000_0000_080C_888C},
        '{'{lcdtn_pkg::OP_START, 8'h00, 8'd15, 8'd0}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_CHAR,  8'h61, 8'h00, 8'h00}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_CHAR,  lcdtn_pkg::CH_NEWLINE, 8'h00, 8'h00}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_START, 8'h00, 8'd15, 8'd1}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_CHAR,  8'h62, 8'h00, 8'h00}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_CHAR,  lcdtn_pkg::CH_RETURN, 8'h00, 8'h00}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_CHAR,  8'hAA, 8'h55, 8'hAA}, 1'b0, 4'd0, 64'd0},
        '{'{lcdtn_pkg::OP_CHAR,  8'h55, 8'hAA, 8'h55}, 1'b0, 4'd0, 64'd0}
    };

    localparam logic [5:0] PHASE_COLS [6] = '{6'd16, 6'd1, 6'd40, 6'd0, 6'd63, 6'd16};
    localparam logic [2:0] PHASE_ROWS [6] = '{3'd2, 3'd1, 3'd4, 3'd0, 3'd7, 3'd2};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_operation = 1'b0;
    logic [7:0]  i_character = '0;
    logic [7:0]  i_start_col = '0;
    logic [7:0]  i_start_row = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_expander_byte;
    logic        o_last_of_run;

    logic [5:0]  cfg_columns = lcdtn_pkg::COLUMNS_RESET;
    logic [2:0]  cfg_rows = lcdtn_pkg::ROWS_RESET;
    logic [5:0]  lcd_col = '0;
    logic [1:0]  lcd_row = '0;
    logic [7:0]  lcd_used = '0;
    logic [7:0]  frame_bytes [$];
    t_due        lcd_bytes_due [$];

    int fail_count = 0;
    bit in_idle_en = 1'b1;
    bit out_idle_en = 1'b1;
    bit hold_req = 1'b0;
    int hold_left = 0;

    lcd_text_to_nibble_frames_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_character     (i_character),
        .i_start_col     (i_start_col),
        .i_start_row     (i_start_row),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_expander_byte (o_expander_byte),
        .o_last_of_run   (o_last_of_run)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // one command or data byte -> four expander bytes, unless the buffer is full
    function automatic void queue_frame(input logic is_data, input logic [7:0] value);
        logic [7:0] hi;
        logic [7:0] lo;
        if (int'(lcd_used) + 4 >= lcdtn_pkg::BUFFER_BYTES) return;
        hi = (value & NIB_HI) | BIT_EN | BIT_BL | (is_data ? BIT_RS : 8'h00);
        lo = {value[3:0], hi[3:0]};
        frame_bytes.push_back(hi);
        frame_bytes.push_back(hi & ~BIT_EN);
        frame_bytes.push_back(lo);
        frame_bytes.push_back(lo & ~BIT_EN);
        lcd_used = lcd_used + 8'd4;
    endfunction

    function automatic void move_cursor(input int col, input int row);
        int nrows;
        nrows = (cfg_rows > lcdtn_pkg::ROWS_MAX) ? int'(lcdtn_pkg::ROWS_MAX) : int'(cfg_rows);
        if (row >= nrows) row = 0;
        if (col >= int'(cfg_columns)) col = 0;
        lcd_col = col[5:0];
        lcd_row = row[1:0];
        queue_frame(1'b0, lcdtn_pkg::CMD_SET_ADDR
                          | ({2'b00, lcd_col} + lcdtn_pkg::ROW_BASE[lcd_row]));
    endfunction

    function automatic void predict_lcd_item(input t_item it);
        frame_bytes.delete();
        if (it.op == lcdtn_pkg::OP_START) begin
            lcd_used = '0;
            move_cursor(int'(it.sc), int'(it.sr));
        end else begin
            if (lcd_col >= cfg_columns) move_cursor(0, int'(lcd_row) + 1);
            if (it.ch == lcdtn_pkg::CH_NEWLINE) begin
                move_cursor(int'(lcd_col), int'(lcd_row) + 1);
            end else if (it.ch == lcdtn_pkg::CH_RETURN) begin
                move_cursor(0, int'(lcd_row));
            end else begin
                queue_frame(1'b1, it.ch);
                lcd_col = lcd_col + 6'd1;
            end
        end
    endfunction

    function automatic t_item random_char();
        t_item c;
        int r;
        c.op = lcdtn_pkg::OP_CHAR;
        c.sc = 8'($urandom_range(255));
        c.sr = 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 10) c.ch = lcdtn_pkg::CH_NEWLINE;
        else if (r < 16) c.ch = lcdtn_pkg::CH_RETURN;
        else if (r < 34) c.ch = 8'($urandom_range(255));
        else c.ch = 8'($urandom_range(8'h7E, 8'h20));
        return c;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input t_item it, input logic typed, input logic [3:0] n_typed,
                             input logic [63:0] typed_bytes);
        int cnt;
        while (in_idle_en && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= it.op;
        i_character <= it.ch;
        i_start_col <= it.sc;
        i_start_row <= it.sr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_lcd_item(it);
        if (typed) begin
            frame_bytes.delete();
            for (int k = 0; k < int'(n_typed); k++) frame_bytes.push_back(typed_bytes[8*k +: 8]);
        end
        cnt = frame_bytes.size();
        for (int k = 0; k < cnt; k++) lcd_bytes_due.push_back('{frame_bytes[k], k == cnt - 1});
        @(negedge i_clk);
    endtask

    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (lcd_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == lcdtn_pkg::REG_COLUMNS) cfg_columns = data[5:0];
        else cfg_rows = data[2:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly start + message runs; some stray characters between them
    task automatic run_random(input int count);
        int done;
        int len;
        t_item it;
        done = 0;
        while (done < count) begin
            if ($urandom_range(99) < 85) begin
                it.op = lcdtn_pkg::OP_START;
                it.ch = 8'($urandom_range(255));
                it.sc = 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                    : $urandom_range(int'(cfg_columns)));
                it.sr = 8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(4));
                send_item(it, 1'b0, 4'd0, 64'd0);
                done++;
                len = ($urandom_range(9) == 0) ? $urandom_range(45, 32) : $urandom_range(20);
            end else begin
                len = $urandom_range(3, 1);
            end
            if (len > count - done) len = count - done;
            repeat (len) begin
                send_item(random_char(), 1'b0, 4'd0, 64'd0);
                done++;
            end
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= out_idle_en && ($urandom_range(99) < 26);
            end
        end
    end

    always @(posedge i_clk) begin
        t_due want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (lcd_bytes_due.size() == 0) begin
                $error("expander_byte: none expected, got %02h", o_expander_byte);
                fail_count++;
            end else begin
                want = lcd_bytes_due.pop_front();
                if (o_expander_byte !== want.data) begin
                    $error("expander_byte: expected %02h, got %02h", want.data, o_expander_byte);
                    fail_count++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0b, got %0b", want.last, o_last_of_run);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [5:0] ncols;
        logic [2:0] nrows;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < $size(DIRECTED); k++)
            send_item(DIRECTED[k].it, DIRECTED[k].typed, DIRECTED[k].n, DIRECTED[k].bytes);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                settle_block();
                ncols = (phase == 5) ? 6'($urandom_range(40, 1)) : PHASE_COLS[phase];
                nrows = (phase == 5) ? 3'($urandom_range(4, 1)) : PHASE_ROWS[phase];
                write_reg(lcdtn_pkg::REG_COLUMNS, {26'd0, ncols});
                write_reg(lcdtn_pkg::REG_ROWS, {29'd0, nrows});
            end
            in_idle_en  = (phase != 2);
            out_idle_en = (phase != 2);
            if (phase == 1) hold_req = 1'b1;
            run_random(34);
            settle_block();
            run_random(33);
        end

        settle_block();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
